/* design/tga_rle_pixel_decoder_macros.svh */
// Assertion macros for the TGA run-length pixel decoder.
// Included by the top level; no other dependencies.
`ifndef TGA_RLE_PIXEL_DECODER_MACROS_SVH
`define TGA_RLE_PIXEL_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent on one cycle implies consequent on the same cycle.
`define TGA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tga_rle_pixel_decoder: implication check failed");
// Antecedent on one cycle implies consequent on the next cycle.
`define TGA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tga_rle_pixel_decoder: next-cycle check failed");
`else
`define TGA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define TGA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/tga_rle_pkg.sv */
// Package for the TGA run-length pixel decoder: types, codes and constants.
// No dependencies; used by every module of the decoder.
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

   // Configuration port.
   localparam int CSR_DATA_WIDTH      = 25;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int PIXEL_COUNT_WIDTH_DEF = 25;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTES_PER_PIXEL = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_COUNT     = 1'd1;

   localparam logic [2:0]                BPP_RESET         = 3'd3;
   localparam logic [CSR_DATA_WIDTH-1:0] PIXEL_COUNT_RESET = 25'd1;

   // Packet header decoding.
   localparam logic [7:0] RUN_HEADER_BIAS = 8'd127;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_CLIP  = 2'd1,
      ST_SHORT = 2'd2
   } status_type;

   // One result transaction.
   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [7:0] repeat_count;
      status_type status;
      logic       image_done;
   } rsp_type;

endpackage

`default_nettype wire

/* design/tga_rle_pixel_decoder.sv */
// Top level of the TGA run-length pixel decoder: packet parsing and pixel output.
// Depends on tga_rle_pkg, tga_rle_rsp_buf and tga_rle_pixel_decoder_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "tga_rle_pixel_decoder_macros.svh"

// The decoder takes one coded image byte per clock cycle while req_ready is high
// and issues at most one result per byte: each completed pixel is registered with
// its repeat count and RGB(A) byte order. All work for a byte is done in a single
// pass between the packet state registers and the result register, so the
// sustained rate is one byte per cycle while req_ready is high. The result register
// is backed by a skid stage; req_ready drops only while both hold a result that the
// consumer has not yet taken. Configuration writes take effect on the next byte.

module tga_rle_pixel_decoder
   import tga_rle_pkg::*;
#(
   parameter int PIXEL_COUNT_WIDTH = PIXEL_COUNT_WIDTH_DEF
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Configuration write port.
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   // Coded byte input.
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_last_byte,
   // Pixel results.
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [7:0]                      rsp_out_byte0,
   output logic [7:0]                      rsp_out_byte1,
   output logic [7:0]                      rsp_out_byte2,
   output logic [7:0]                      rsp_out_byte3,
   output logic [7:0]                      rsp_repeat_count,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_image_done
);

   localparam int PCW = PIXEL_COUNT_WIDTH;

   // Configuration registers.
   logic [2:0]                bpp_ff;
   logic [CSR_DATA_WIDTH-1:0] pixel_count_ff;

   // Packet and image state.
   logic           expect_header_ff,  expect_header_in;
   logic           packet_is_run_ff,  packet_is_run_in;
   logic [7:0]     packet_left_ff,    packet_left_in;
   logic [1:0]     byte_in_pixel_ff,  byte_in_pixel_in;
   logic [23:0]    pixel_bytes_ff,    pixel_bytes_in;
   logic [PCW-1:0] pixels_written_ff, pixels_written_in;
   logic           image_finished_ff, image_finished_in;

   logic                       accept;
   logic                       push;
   logic                       push_ready;
   rsp_type                    push_data;
   rsp_type                    rsp_data;
   logic                       clear_image;
   logic [1:0]                 size_m1;
   logic                       pixel_complete;
   logic [PCW+CSR_DATA_WIDTH-1:0] pc_ext;
   logic [PCW-1:0]             pc_used;
   logic [PCW-1:0]             total;
   logic [PCW-1:0]             remaining;
   logic [7:0]                 rep_req;
   logic [PCW-1:0]             rep_req_ext;
   logic [7:0]                 rep_final;
   logic                       rep_clip;
   logic                       rep_exact;
   logic [7:0]                 left_after;

   assign accept = req_valid && req_ready;

   // Pixel size in bytes minus one; unsupported sizes decode as three bytes.
   always_comb begin
      case (bpp_ff)
         3'd1:    size_m1 = 2'd0;
         3'd4:    size_m1 = 2'd3;
         default: size_m1 = 2'd2;
      endcase
   end

   assign pixel_complete = (byte_in_pixel_ff >= size_m1);

   // Image size in use: low bits of the register, zero treated as one.
   assign pc_ext  = {{PCW{1'b0}}, pixel_count_ff};
   assign pc_used = pc_ext[PCW-1:0];
   assign total   = (pc_used == '0) ? PCW'(1) : pc_used;
   assign remaining = (pixels_written_ff < total) ? (total - pixels_written_ff) : '0;

   // Repeat count of the pixel being completed, clipped to the image end.
   assign rep_req     = packet_is_run_ff ? packet_left_ff : 8'd1;
   assign rep_req_ext = PCW'(rep_req);
   assign rep_clip    = (rep_req_ext > remaining);
   assign rep_exact   = (rep_req_ext == remaining);
   assign rep_final   = rep_clip ? remaining[7:0] : rep_req;
   assign left_after  = packet_is_run_ff ? 8'd0 : (packet_left_ff - 8'd1);

   // Next state and result for one accepted byte.
   always_comb begin
      expect_header_in  = expect_header_ff;
      packet_is_run_in  = packet_is_run_ff;
      packet_left_in    = packet_left_ff;
      byte_in_pixel_in  = byte_in_pixel_ff;
      pixel_bytes_in    = pixel_bytes_ff;
      pixels_written_in = pixels_written_ff;
      image_finished_in = image_finished_ff;
      clear_image       = 1'b0;
      push              = 1'b0;
      push_data         = '0;
      push_data.status  = ST_OK;

      if (accept) begin
         if (image_finished_ff) begin
            // Trailing bytes after a complete image are dropped.
            clear_image = req_last_byte;
         end else if (expect_header_ff) begin
            // Packet header: raw count below 128, run count otherwise.
            if (!req_data_byte[7]) begin
               packet_is_run_in = 1'b0;
               packet_left_in   = req_data_byte + 8'd1;
            end else begin
               packet_is_run_in = 1'b1;
               packet_left_in   = req_data_byte - RUN_HEADER_BIAS;
            end
            expect_header_in = 1'b0;
            byte_in_pixel_in = 2'd0;
            pixel_bytes_in   = '0;
            if (req_last_byte) begin
               push                 = 1'b1;
               push_data.status     = ST_SHORT;
               push_data.image_done = 1'b1;
               clear_image          = 1'b1;
            end
         end else if (!pixel_complete) begin
            // Collect a leading byte of the pixel.
            case (byte_in_pixel_ff)
               2'd0:    pixel_bytes_in[7:0]   = pixel_bytes_ff[7:0]   | req_data_byte;
               2'd1:    pixel_bytes_in[15:8]  = pixel_bytes_ff[15:8]  | req_data_byte;
               2'd2:    pixel_bytes_in[23:16] = pixel_bytes_ff[23:16] | req_data_byte;
               default: pixel_bytes_in        = pixel_bytes_ff;
            endcase
            byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
            if (req_last_byte) begin
               push                 = 1'b1;
               push_data.status     = ST_SHORT;
               push_data.image_done = 1'b1;
               clear_image          = 1'b1;
            end
         end else begin
            // Final byte of a pixel: reorder and emit it with its count.
            case (size_m1)
               2'd0: begin
                  push_data.out_byte0 = req_data_byte;
               end
               2'd3: begin
                  push_data.out_byte0 = pixel_bytes_ff[23:16];
                  push_data.out_byte1 = pixel_bytes_ff[15:8];
                  push_data.out_byte2 = pixel_bytes_ff[7:0];
                  push_data.out_byte3 = req_data_byte;
               end
               default: begin
                  push_data.out_byte0 = req_data_byte;
                  push_data.out_byte1 = pixel_bytes_ff[15:8];
                  push_data.out_byte2 = pixel_bytes_ff[7:0];
               end
            endcase
            byte_in_pixel_in  = 2'd0;
            pixel_bytes_in    = '0;
            packet_left_in    = left_after;
            expect_header_in  = (left_after == 8'd0) ? 1'b1 : expect_header_ff;
            pixels_written_in = pixels_written_ff + PCW'(rep_final);
            image_finished_in = rep_clip || rep_exact;
            push                   = 1'b1;
            push_data.repeat_count = rep_final;
            push_data.image_done   = rep_clip || rep_exact || req_last_byte;
            if (rep_clip) begin
               push_data.status = ST_CLIP;
            end else if (req_last_byte && !rep_exact) begin
               push_data.status = ST_SHORT;
            end
            clear_image = req_last_byte;
         end
      end

      // End of file data returns the image state to its reset values.
      if (clear_image) begin
         expect_header_in  = 1'b1;
         packet_is_run_in  = 1'b0;
         packet_left_in    = '0;
         byte_in_pixel_in  = '0;
         pixel_bytes_in    = '0;
         pixels_written_in = '0;
         image_finished_in = 1'b0;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= BPP_RESET;
         pixel_count_ff <= PIXEL_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_ff         <= csr_wdata[2:0];
            CSR_PIXEL_COUNT:     pixel_count_ff <= csr_wdata;
            default:             bpp_ff         <= bpp_ff;
         endcase
      end
   end

   // Packet and image state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_header_ff  <= 1'b1;
         packet_is_run_ff  <= 1'b0;
         packet_left_ff    <= '0;
         byte_in_pixel_ff  <= '0;
         pixel_bytes_ff    <= '0;
         pixels_written_ff <= '0;
         image_finished_ff <= 1'b0;
      end else begin
         expect_header_ff  <= expect_header_in;
         packet_is_run_ff  <= packet_is_run_in;
         packet_left_ff    <= packet_left_in;
         byte_in_pixel_ff  <= byte_in_pixel_in;
         pixel_bytes_ff    <= pixel_bytes_in;
         pixels_written_ff <= pixels_written_in;
         image_finished_ff <= image_finished_in;
      end
   end

   // Result register and skid stage.
   tga_rle_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign req_ready        = push_ready;
   assign rsp_out_byte0    = rsp_data.out_byte0;
   assign rsp_out_byte1    = rsp_data.out_byte1;
   assign rsp_out_byte2    = rsp_data.out_byte2;
   assign rsp_out_byte3    = rsp_data.out_byte3;
   assign rsp_repeat_count = rsp_data.repeat_count;
   assign rsp_status       = rsp_data.status;
   assign rsp_image_done   = rsp_data.image_done;

   // Input is stalled only while the result register holds a transaction.
   `TGA_ASSERT_IMPLY(a_stall_needs_result, clock, reset, !req_ready, rsp_valid)
   // Clipped and short results always close the image.
   `TGA_ASSERT_IMPLY(a_error_closes_image, clock, reset,
      rsp_valid && (rsp_status == ST_CLIP || rsp_status == ST_SHORT), rsp_image_done)
   // A truncation result with a zero repeat count never carries pixel data.
   `TGA_ASSERT_IMPLY(a_zero_count_no_data, clock, reset,
      rsp_valid && rsp_status == ST_SHORT && rsp_repeat_count == 8'd0,
      rsp_out_byte0 == 8'd0 && rsp_out_byte1 == 8'd0 &&
      rsp_out_byte2 == 8'd0 && rsp_out_byte3 == 8'd0)
   // The last byte of the file always leaves the decoder waiting for a header.
   `TGA_ASSERT_NEXT(a_last_byte_clears, clock, reset,
      accept && req_last_byte, expect_header_ff && !image_finished_ff)

endmodule

`default_nettype wire

/* design/tga_rle_rsp_buf.sv */
// Result register with a skid stage for the TGA run-length pixel decoder.
// Depends on tga_rle_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_rsp_buf
   import tga_rle_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         push_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   // A new result can always be taken while the skid stage is empty.
   assign push_ready = !skid_valid_ff;
   assign pop        = out_valid_ff && rsp_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;

   // Move results between the output register and the skid stage.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   // Valid flags are reset; the payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire
